FILE: hdl/mcdht_pkg.sv
// Package: shared types, constants and the frame decode function of the DHT22 receiver.
`default_nettype none
package mcdht_pkg;
    localparam int CHANNELS_DEF    = 8;
    localparam int FRAME_BITS_DEF  = 40;
    localparam int TIMER_WIDTH_DEF = 17;

    localparam logic [2:0] REG_MASK      = 3'd0;
    localparam logic [2:0] REG_START_LOW = 3'd1;
    localparam logic [2:0] REG_RESP_LOW  = 3'd2;
    localparam logic [2:0] REG_RESP_HIGH = 3'd3;
    localparam logic [2:0] REG_ONE_THR   = 3'd4;
    localparam logic [2:0] REG_TIMEOUT   = 3'd5;

    localparam logic       REQ_TICK  = 1'b0;
    localparam logic       REQ_START = 1'b1;
    localparam logic       KIND_STATUS  = 1'b0;
    localparam logic       KIND_READING = 1'b1;
    localparam logic [1:0] ST_RUN      = 2'd0;
    localparam logic [1:0] ST_OK       = 2'd1;
    localparam logic [1:0] ST_NODEV    = 2'd2;
    localparam logic [1:0] ST_CHECKSUM = 2'd3;

    localparam int MAX_EMIT = 8;
    localparam int OUT_W    = 43;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_START     = 3'd1,
        PH_RESP_LOW  = 3'd2,
        PH_RESP_HIGH = 3'd3,
        PH_DATA      = 3'd4
    } t_phase;

    typedef struct packed {
        logic        last;
        logic        checksum_ok;
        logic [15:0] temperature_tenths;
        logic [15:0] humidity_tenths;
        logic        channel_enabled;
        logic [2:0]  channel;
        logic [1:0]  status;
        logic        busy_res;
        logic        drive_low;
        logic        kind;
    } t_result;

    typedef struct packed {
        logic [15:0] hum;
        logic [15:0] temp;
        logic        ok;
    } t_decoded;

    // Byte 0 is the oldest received byte (bits 39..32 of the shift register).
    function automatic t_decoded decode_frame(input logic [39:0] f);
        t_decoded   d;
        logic [7:0] b0, b1, b2, b3, b4, s;
        logic [15:0] mag;
        b0 = f[39:32]; b1 = f[31:24]; b2 = f[23:16]; b3 = f[15:8]; b4 = f[7:0];
        s = b0 + b1 + b2 + b3;
        mag = {1'b0, b2[6:0], b3};
        d.hum = {b0, b1};
        d.temp = b2[7] ? (16'd0 - mag) : mag;
        d.ok = (s == b4);
        return d;
    endfunction
endpackage
`default_nettype wire

FILE: hdl/multi_channel_dht22_receiver_core.sv
// Top level of the multi-channel DHT22 receiver: control, channels and result queue.
// A status item is registered at the input, then written to the queue, which offers it.
// Throughput: one input item per cycle while the result queue has room; a measurement
// end yields one reading item per channel, up to eight, drained one per cycle on tready.
// The input is held off once two items wait, unless one leaves and none is in flight.
// Reset (synchronous, active low) restores register defaults, idle phase, empty queue.
`default_nettype none
module multi_channel_dht22_receiver_core import mcdht_pkg::*; #(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int FRAME_BITS  = FRAME_BITS_DEF,
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // pin_levels[7:0]
    input  wire logic        s_axis_tuser,   // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // drive_low, busy_res, status[1:0], channel[2:0],
                                             // channel_enabled, humidity_tenths[15:0],
                                             // temperature_tenths[15:0], checksum_ok, zero fill
    output logic             m_axis_tuser,   // kind
    output logic             m_axis_tlast    // last
);
    localparam int NEMIT = (CHANNELS < MAX_EMIT) ? CHANNELS : MAX_EMIT;
    localparam int QD    = NEMIT + 2;
    localparam int QW    = $clog2(QD);
    localparam int SW    = QW + 1;
    localparam int CW    = $clog2(QD + 1);
    localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

    // Configuration registers.
    logic [7:0]  r_mask;
    logic [15:0] r_start_low, r_resp_low, r_resp_high, r_one_thr, r_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= 8'd0; r_start_low <= 16'd39600; r_resp_low <= 16'd5040;
            r_resp_high <= 16'd5760; r_one_thr <= 16'd7200; r_timeout <= 16'd36000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MASK:      r_mask      <= i_cfg_data[7:0];
                REG_START_LOW: r_start_low <= i_cfg_data;
                REG_RESP_LOW:  r_resp_low  <= i_cfg_data;
                REG_RESP_HIGH: r_resp_high <= i_cfg_data;
                REG_ONE_THR:   r_one_thr   <= i_cfg_data;
                REG_TIMEOUT:   r_timeout   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: the accepted item is worked on in the following cycle.
    logic       r_in_v, r_req;
    logic [7:0] r_pins;
    logic       w_acc;
    logic [CW-1:0] r_cnt;

    // The queue must hold every item of a measurement end plus one in flight.
    assign s_axis_tready = (r_cnt <= CW'(1)) || (r_cnt == CW'(2) && !r_in_v && m_axis_tready);
    assign w_acc = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_in_v <= 1'b0;
        else          r_in_v <= w_acc;
        if (w_acc) begin
            r_req <= s_axis_tuser; r_pins <= s_axis_tdata;
        end
    end

    // Phase control.
    t_phase r_phase, n_phase;
    logic [TIMER_WIDTH-1:0] r_el, n_el, w_el_inc;
    logic [7:0] r_prev, n_prev;
    logic w_clear, w_restart, w_data, w_end, w_nodev;
    logic [7:0] w_fall, w_mask;
    logic [CHANNELS-1:0] w_busy;
    logic [FRAME_BITS-1:0] w_frame [CHANNELS];

    always_comb begin
        w_mask = r_mask;
        w_fall = r_prev & ~r_pins & w_mask;
        w_el_inc = (r_el == TMAX) ? r_el : r_el + 1'b1;
    end

    always_comb begin
        n_phase = r_phase; n_el = r_el; n_prev = r_prev;
        w_clear = 1'b0; w_restart = 1'b0; w_data = 1'b0; w_end = 1'b0; w_nodev = 1'b0;
        if (r_in_v) begin
            if (r_req == REQ_START) begin
                if (r_phase == PH_IDLE) begin
                    w_clear = 1'b1; n_phase = PH_START; n_el = '0;
                end
            end else begin
                case (r_phase)
                    PH_IDLE: ;
                    PH_START: begin
                        n_el = w_el_inc;
                        if (w_el_inc > TIMER_WIDTH'(r_start_low)) begin
                            n_phase = PH_RESP_LOW; n_el = '0;
                        end
                    end
                    PH_RESP_LOW: begin
                        n_el = w_el_inc;
                        if (w_el_inc >= TIMER_WIDTH'(r_resp_low)) begin
                            n_el = '0;
                            if ((r_pins & w_mask) != 8'd0) begin
                                n_phase = PH_IDLE; w_nodev = 1'b1;
                            end else n_phase = PH_RESP_HIGH;
                        end
                    end
                    PH_RESP_HIGH: begin
                        n_el = w_el_inc;
                        if (w_el_inc >= TIMER_WIDTH'(r_resp_high)) begin
                            n_el = '0;
                            if ((~r_pins & w_mask) != 8'd0) begin
                                n_phase = PH_IDLE; w_nodev = 1'b1;
                            end else begin
                                n_phase = PH_DATA; n_prev = r_pins; w_restart = 1'b1;
                            end
                        end
                    end
                    PH_DATA: begin
                        w_data = 1'b1; n_prev = r_pins;
                        if (w_busy == '0) begin
                            n_phase = PH_IDLE; n_el = '0; w_end = 1'b1;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_el <= '0; r_prev <= 8'hFF;
        end else begin
            r_phase <= n_phase; r_el <= n_el; r_prev <= n_prev;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CHANNELS; g++) begin : g_ch
            localparam int MI = (g < 8) ? g : 0;
            logic w_en;
            assign w_en = (g < 8) && w_mask[MI];
            mcdht_chan #(.FRAME_BITS(FRAME_BITS), .TIMER_WIDTH(TIMER_WIDTH)) u_ch (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(w_clear),
                .i_restart(w_restart), .i_step(w_data && w_en),
                .i_fall(w_fall[MI]), .i_one_thr(r_one_thr), .i_timeout(r_timeout),
                .o_busy(w_busy[g]), .o_frame(w_frame[g]));
        end
    endgenerate

    // Result assembly: the end reading uses frames as they stand before the last
    // tick, which is correct because the last tick has no counted edge.
    t_result  w_st;
    t_result  w_rd [NEMIT];
    t_decoded w_dec [NEMIT];
    logic     w_all_ok;

    always_comb begin
        w_all_ok = 1'b1;
        for (int i = 0; i < NEMIT; i++) begin
            w_dec[i] = decode_frame(40'(w_frame[i][FRAME_BITS-1:0]));
            if (w_mask[i] && !w_dec[i].ok) w_all_ok = 1'b0;
        end
        for (int i = 0; i < NEMIT; i++) begin
            w_rd[i] = '0;
            w_rd[i].kind = KIND_READING;
            w_rd[i].status = w_all_ok ? ST_OK : ST_CHECKSUM;
            w_rd[i].channel = 3'(i);
            w_rd[i].last = (i == NEMIT - 1);
            if (w_mask[i]) begin
                w_rd[i].channel_enabled = 1'b1;
                w_rd[i].humidity_tenths = w_dec[i].hum;
                w_rd[i].temperature_tenths = w_dec[i].temp;
                w_rd[i].checksum_ok = w_dec[i].ok;
            end
        end
        w_st = '0;
        w_st.kind = KIND_STATUS;
        w_st.last = 1'b1;
        if (w_nodev) w_st.status = ST_NODEV;
        else begin
            w_st.drive_low = (n_phase == PH_START);
            w_st.busy_res = (n_phase != PH_IDLE);
        end
    end

    // Output queue.
    t_result r_q [QD];
    logic [QW-1:0] r_rd, r_wr;
    logic w_pop;
    logic [CW-1:0] w_push_n;
    logic [QW-1:0] w_widx [NEMIT];
    logic [QW-1:0] w_wr_nxt;
    logic [SW-1:0] w_sum, w_wr_sum;

    assign w_pop = m_axis_tvalid && m_axis_tready;
    assign w_push_n = !r_in_v ? CW'(0) : (w_end ? CW'(NEMIT) : CW'(1));

    // Write pointers wrap by one compare and subtract, as no sum reaches twice the depth.
    always_comb begin
        for (int i = 0; i < NEMIT; i++) begin
            w_sum = {1'b0, r_wr} + SW'(i);
            w_widx[i] = (w_sum >= SW'(QD)) ? QW'(w_sum - SW'(QD)) : QW'(w_sum);
        end
        w_wr_sum = {1'b0, r_wr} + SW'(w_push_n);
        w_wr_nxt = (w_wr_sum >= SW'(QD)) ? QW'(w_wr_sum - SW'(QD)) : QW'(w_wr_sum);
    end

    always_ff @(posedge i_clk) begin
        if (r_in_v) begin
            if (w_end) begin
                for (int i = 0; i < NEMIT; i++)
                    r_q[w_widx[i]] <= w_rd[i];
            end else r_q[r_wr] <= w_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0; r_wr <= '0; r_cnt <= '0;
        end else begin
            r_wr <= w_wr_nxt;
            if (w_pop) r_rd <= (r_rd == QW'(QD - 1)) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + w_push_n - CW'(w_pop);
        end
    end

    t_result w_head;
    assign w_head = r_q[r_rd];
    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tuser = w_head.kind;
    assign m_axis_tlast = w_head.last;
    assign m_axis_tdata = {5'd0, w_head.checksum_ok, w_head.temperature_tenths,
                           w_head.humidity_tenths, w_head.channel_enabled, w_head.channel,
                           w_head.status, w_head.busy_res, w_head.drive_low};

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(QD)) else $error("queue overflow");
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end |=> r_phase == PH_IDLE) else $error("end not idle");
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear |-> r_phase == PH_IDLE) else $error("start while busy");
    a_nodev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_nodev |-> (r_phase == PH_RESP_LOW || r_phase == PH_RESP_HIGH))
        else $error("bad no-device");
endmodule
`default_nettype wire

FILE: hdl/mcdht_chan.sv
// One channel's edge timer and bit shift register for the data phase.
`default_nettype none
module mcdht_chan import mcdht_pkg::*; #(
    parameter int FRAME_BITS  = FRAME_BITS_DEF,
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_clear,     // start of measurement
    input  wire logic                   i_restart,   // data phase entry
    input  wire logic                   i_step,      // data tick and channel enabled
    input  wire logic                   i_fall,
    input  wire logic [15:0]            i_one_thr,
    input  wire logic [15:0]            i_timeout,
    output logic                        o_busy,
    output logic [FRAME_BITS-1:0]       o_frame
);
    localparam int ECW = $clog2(FRAME_BITS + 2);
    localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

    logic [ECW-1:0]         r_edges, n_edges;
    logic [TIMER_WIDTH-1:0] r_since, n_since, w_inc;
    logic [FRAME_BITS-1:0]  r_frame, n_frame;
    logic                   w_take;

    always_comb begin
        w_inc = (r_since == TMAX) ? r_since : r_since + 1'b1;
        w_take = i_fall && (r_edges < ECW'(FRAME_BITS + 1));
        n_edges = r_edges;
        n_since = r_since;
        n_frame = r_frame;
        o_busy = 1'b0;
        if (i_clear) begin
            n_edges = '0; n_since = '0; n_frame = '0;
        end else if (i_restart) begin
            n_since = '0;
        end else if (i_step) begin
            n_since = w_inc;
            if (w_take) begin
                o_busy = 1'b1;
                if (r_edges != '0)
                    n_frame = {r_frame[FRAME_BITS-2:0],
                               (w_inc >= TIMER_WIDTH'(i_one_thr))};
                n_edges = r_edges + 1'b1;
                n_since = '0;
            end else if (w_inc <= TIMER_WIDTH'(i_timeout)) begin
                o_busy = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edges <= '0; r_since <= '0; r_frame <= '0;
        end else begin
            r_edges <= n_edges; r_since <= n_since; r_frame <= n_frame;
        end
    end
    assign o_frame = r_frame;
endmodule
`default_nettype wire

FILE: tb/multi_channel_dht22_receiver_core_test.sv
// Self-checking testbench of the multi-channel DHT22 receiver core.
`default_nettype none
module multi_channel_dht22_receiver_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mcdht_pkg::*;

    localparam int TIMER_MAX   = (1 << TIMER_WIDTH_DEF) - 1;
    localparam int STALL_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // pin_levels[7:0]
    logic        s_axis_tuser = 1'b0; // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // drive_low, busy_res, status, channel, channel_enabled,
                                      // humidity, temperature, checksum_ok, zero fill
    logic        m_axis_tuser;        // kind
    logic        m_axis_tlast;        // last

    multi_channel_dht22_receiver_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the configuration registers, updated as they are written.
    logic [7:0]  chan_mask;
    logic [15:0] start_low, resp_low, resp_high, one_thr, edge_timeout;

    // Shadow copy of the receiver state.
    t_phase      ph;
    int          ph_el;
    logic [7:0]  prev_pins;
    int          edge_cnt [8];
    int          since [8];
    logic [39:0] frame [8];

    t_result     pending_results [$];
    bit          sensor_wave [8][$];

    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    function automatic int sat_inc(input int v);
        return (v >= TIMER_MAX) ? TIMER_MAX : v + 1;
    endfunction

    // Builds the reading items of all eight channels at the end of a measurement.
    task automatic emit_readings();
        t_result     r;
        logic [7:0]  b0, b1, b2, b3, b4;
        logic [14:0] mag;
        bit          all_ok;
        all_ok = 1'b1;
        for (int i = 0; i < 8; i++) begin
            {b0, b1, b2, b3, b4} = frame[i];
            if (chan_mask[i] && (8'(b0 + b1 + b2 + b3) != b4))
                all_ok = 1'b0;
        end
        for (int i = 0; i < 8; i++) begin
            r = '0;
            r.kind = KIND_READING;
            r.status = all_ok ? ST_OK : ST_CHECKSUM;
            r.channel = 3'(i);
            r.last = (i == 7);
            if (chan_mask[i]) begin
                {b0, b1, b2, b3, b4} = frame[i];
                mag = {b2[6:0], b3};
                r.channel_enabled = 1'b1;
                r.humidity_tenths = {b0, b1};
                r.temperature_tenths = b2[7] ? 16'(-int'(mag)) : 16'(mag);
                r.checksum_ok = (8'(b0 + b1 + b2 + b3) == b4);
            end
            pending_results.push_back(r);
        end
    endtask

    // Advances the shadow state by one accepted item and queues what it yields.
    task automatic sensor_step(input logic req, input logic [7:0] pins);
        t_result    r;
        logic [7:0] fall;
        bit         busy;
        r = '0;
        r.kind = KIND_STATUS;
        r.last = 1'b1;
        if (req == REQ_START) begin
            if (ph == PH_IDLE) begin
                for (int i = 0; i < 8; i++) begin
                    edge_cnt[i] = 0;
                    since[i] = 0;
                    frame[i] = '0;
                end
                ph = PH_START;
                ph_el = 0;
            end
        end else begin
            case (ph)
                PH_START: begin
                    ph_el = sat_inc(ph_el);
                    if (ph_el > start_low) begin
                        ph = PH_RESP_LOW;
                        ph_el = 0;
                    end
                end
                PH_RESP_LOW: begin
                    ph_el = sat_inc(ph_el);
                    if (ph_el >= resp_low) begin
                        ph_el = 0;
                        if ((pins & chan_mask) != 0) begin
                            ph = PH_IDLE;
                            r.status = ST_NODEV;
                            pending_results.push_back(r);
                            return;
                        end
                        ph = PH_RESP_HIGH;
                    end
                end
                PH_RESP_HIGH: begin
                    ph_el = sat_inc(ph_el);
                    if (ph_el >= resp_high) begin
                        ph_el = 0;
                        if ((~pins & chan_mask) != 0) begin
                            ph = PH_IDLE;
                            r.status = ST_NODEV;
                            pending_results.push_back(r);
                            return;
                        end
                        ph = PH_DATA;
                        prev_pins = pins;
                        for (int i = 0; i < 8; i++) since[i] = 0;
                    end
                end
                PH_DATA: begin
                    busy = 1'b0;
                    fall = prev_pins & ~pins & chan_mask;
                    for (int i = 0; i < 8; i++) begin
                        if (chan_mask[i]) begin
                            since[i] = sat_inc(since[i]);
                            if (fall[i] && edge_cnt[i] < 41) begin
                                busy = 1'b1;
                                // The first edge only marks the start of the data.
                                if (edge_cnt[i] >= 1)
                                    frame[i] = {frame[i][38:0], since[i] >= one_thr};
                                edge_cnt[i]++;
                                since[i] = 0;
                            end else if (since[i] <= edge_timeout) begin
                                busy = 1'b1;
                            end
                        end
                    end
                    prev_pins = pins;
                    if (!busy) begin
                        ph = PH_IDLE;
                        ph_el = 0;
                        emit_readings();
                        return;
                    end
                end
                default: ph = PH_IDLE;
            endcase
        end
        r.drive_low = (ph == PH_START);
        r.busy_res = (ph != PH_IDLE);
        pending_results.push_back(r);
    endtask

    task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
        $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Offers one item, with random idle cycles before it, and waits for its acceptance.
    task automatic send_item(input logic req, input logic [7:0] pins);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= pins;
        do @(posedge i_clk); while (!s_axis_tready);
        sensor_step(req, pins);
    endtask

    // Stops offering items until every expected result has come out, then lets the
    // block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MASK:      chan_mask = val[7:0];
            REG_START_LOW: start_low = val;
            REG_RESP_LOW:  resp_low = val;
            REG_RESP_HIGH: resp_high = val;
            REG_ONE_THR:   one_thr = val;
            REG_TIMEOUT:   edge_timeout = val;
            default: ;
        endcase
    endtask

    task automatic set_timing(input int s, input int rl, input int rh, input int thr,
                              input int tmo);
        write_reg(REG_START_LOW, 16'(s));
        write_reg(REG_RESP_LOW, 16'(rl));
        write_reg(REG_RESP_HIGH, 16'(rh));
        write_reg(REG_ONE_THR, 16'(thr));
        write_reg(REG_TIMEOUT, 16'(tmo));
    endtask

    // Prepares the line waveform of every enabled sensor: a start marker edge, then one
    // edge per data bit, spaced short for a zero and long for a one. Below a full frame the
    // edge count is drawn at random up to the given count; full ones may be cut or padded.
    task automatic build_waves(input bit bad_sum, input int max_edges);
        logic [7:0] b [5];
        logic [39:0] bits;
        int edges, gap, g0, g1;
        for (int ch = 0; ch < 8; ch++) begin
            sensor_wave[ch].delete();
            if (chan_mask[ch]) begin
                for (int k = 0; k < 4; k++) b[k] = 8'($urandom);
                b[4] = b[0] + b[1] + b[2] + b[3];
                if (bad_sum) b[4] = b[4] ^ 8'($urandom_range(1, 255));
                bits = {b[0], b[1], b[2], b[3], b[4]};
                g0 = (one_thr > 2 && one_thr <= 16) ? $urandom_range(2, one_thr - 1) : 2;
                g1 = (one_thr <= 16) ? ((one_thr < 2) ? 2 : one_thr) : 2;
                if (max_edges < 41)
                    edges = $urandom_range(0, max_edges);
                else if ($urandom_range(9) == 0)
                    edges = $urandom_range(0, 40);
                else if ($urandom_range(5) == 0)
                    edges = 41 + $urandom_range(1, 3);
                else
                    edges = 41;
                for (int e = 0; e < edges; e++) begin
                    if (e == 0 || e > 40)
                        gap = $urandom_range(2, 5);
                    else
                        gap = bits[40 - e] ? g1 + $urandom_range(0, 1) : g0;
                    sensor_wave[ch].push_back(1'b0);
                    repeat (gap - 1) sensor_wave[ch].push_back(1'b1);
                end
            end
        end
    endtask

    // One measurement from start to its final item. A fault of 1 or 2 spoils the
    // low or the high response; a fault of 3 throws in starts while busy.
    task automatic run_measurement(input int fault, input int max_edges);
        logic [7:0] pins;
        build_waves($urandom_range(4) == 0, max_edges);
        send_item(REQ_START, 8'($urandom));
        while (ph != PH_IDLE) begin
            pins = 8'($urandom);
            case (ph)
                PH_RESP_LOW: begin
                    pins = pins & ~chan_mask;
                    if (fault == 1) pins = pins | (chan_mask & 8'($urandom));
                end
                PH_RESP_HIGH: begin
                    pins = pins | chan_mask;
                    if (fault == 2) pins = pins & ~(chan_mask & 8'($urandom));
                end
                PH_DATA: begin
                    for (int ch = 0; ch < 8; ch++)
                        if (chan_mask[ch])
                            pins[ch] = sensor_wave[ch].size() ? sensor_wave[ch].pop_front() : 1'b1;
                end
                default: ;
            endcase
            if (fault == 3 && $urandom_range(19) == 0)
                send_item(REQ_START, pins);
            else
                send_item(REQ_TICK, pins);
        end
    endtask

    task automatic test_idle_ticks();
        send_item(REQ_TICK, 8'h00);
        send_item(REQ_TICK, 8'hFF);
        send_item(REQ_TICK, 8'h55);
        send_item(REQ_TICK, 8'hAA);
    endtask

    task automatic test_empty_mask();
        set_timing(1, 1, 1, 4, 12);
        write_reg(REG_MASK, 8'h00);
        run_measurement(0, 0);
        run_measurement(3, 0);
    endtask

    task automatic test_no_device();
        write_reg(REG_MASK, 8'hFF);
        write_reg(REG_RESP_LOW, 16'd3);
        write_reg(REG_RESP_HIGH, 16'd2);
        run_measurement(1, 6);
        run_measurement(2, 6);
    endtask

    task automatic test_full_frames();
        set_timing(1, 2, 2, 3, 6);
        write_reg(REG_MASK, 8'hFF);
        run_measurement(0, 41);
    endtask

    // Threshold of one decodes every gap as a one; the largest threshold only zeros.
    task automatic test_threshold_extremes();
        write_reg(REG_MASK, 8'h3C);
        write_reg(REG_ONE_THR, 16'd1);
        run_measurement(0, 6);
        write_reg(REG_ONE_THR, 16'hFFFF);
        run_measurement(0, 6);
        write_reg(REG_ONE_THR, 16'd4);
        write_reg(REG_TIMEOUT, 16'd1);
        run_measurement(0, 6);
    endtask

    // Uneven phase lengths, with and without an attached sensor.
    task automatic test_timer_values();
        write_reg(REG_MASK, 8'h00);
        set_timing(5, 4, 3, 4, 2);
        run_measurement(0, 0);
        set_timing(3, 1, 1, 3, 3);
        write_reg(REG_MASK, 8'h01);
        run_measurement(0, 6);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int runs);
        int thr;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < runs; n++) begin
            thr = $urandom_range(3, 5);
            write_reg(REG_MASK, ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom));
            set_timing($urandom_range(1, 4), $urandom_range(1, 3), $urandom_range(1, 3), thr,
                       ($urandom_range(7) == 0) ? $urandom_range(1, 6)
                                                : thr + $urandom_range(2, 4));
            repeat ($urandom_range(0, 3)) send_item(REQ_TICK, 8'($urandom));
            run_measurement(($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0, 4);
        end
    endtask

    // The receiver holds off while ticks keep coming, so the output queue fills and
    // the input must stall; afterwards the sender waits for everything to drain.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 300;
        repeat (12) send_item(REQ_TICK, 8'($urandom));
        write_reg(REG_MASK, 8'hF0);
        hold_left = 200;
        run_measurement(0, 4);
        drain();
    endtask

    // Long receiver hold-offs, counted down in a process of their own.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker: each accepted item against the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report("unexpected item", m_axis_tdata, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser != want.kind)
                    report("kind", 48'(m_axis_tuser), 48'(want.kind));
                if (m_axis_tdata[0] != want.drive_low)
                    report("drive_low", 48'(m_axis_tdata[0]), 48'(want.drive_low));
                if (m_axis_tdata[1] != want.busy_res)
                    report("busy_res", 48'(m_axis_tdata[1]), 48'(want.busy_res));
                if (m_axis_tdata[3:2] != want.status)
                    report("status", 48'(m_axis_tdata[3:2]), 48'(want.status));
                if (m_axis_tdata[6:4] != want.channel)
                    report("channel", 48'(m_axis_tdata[6:4]), 48'(want.channel));
                if (m_axis_tdata[7] != want.channel_enabled)
                    report("channel_enabled", 48'(m_axis_tdata[7]),
                           48'(want.channel_enabled));
                if (m_axis_tdata[23:8] != want.humidity_tenths)
                    report("humidity_tenths", 48'(m_axis_tdata[23:8]),
                           48'(want.humidity_tenths));
                if (m_axis_tdata[39:24] != want.temperature_tenths)
                    report("temperature_tenths", 48'(m_axis_tdata[39:24]),
                           48'(want.temperature_tenths));
                if (m_axis_tdata[40] != want.checksum_ok)
                    report("checksum_ok", 48'(m_axis_tdata[40]), 48'(want.checksum_ok));
                if (m_axis_tdata[47:41] != '0)
                    report("zero fill", 48'(m_axis_tdata[47:41]), '0);
                if (m_axis_tlast != want.last)
                    report("last", 48'(m_axis_tlast), 48'(want.last));
            end
        end
    end

    // Watchdog: ends the run once nothing has moved for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we
                || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        chan_mask = 8'h00;
        start_low = 16'd39600;
        resp_low = 16'd5040;
        resp_high = 16'd5760;
        one_thr = 16'd7200;
        edge_timeout = 16'd36000;
        ph = PH_IDLE;
        ph_el = 0;
        prev_pins = 8'hFF;
        for (int i = 0; i < 8; i++) begin
            edge_cnt[i] = 0;
            since[i] = 0;
            frame[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_ticks();
        test_empty_mask();
        test_no_device();
        test_full_frames();
        test_threshold_extremes();
        test_timer_values();
        test_random_traffic(0, 0, 1);
        test_random_traffic(68, 0, 1);
        test_random_traffic(0, 68, 1);
        test_random_traffic(27, 27, 1);
        test_backpressure();

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
